// File: design/rlti_pkg.sv
// shared types and constants for the radix literal to integer converter
`default_nettype none

package rlti_pkg;

   typedef enum logic [1:0] {
      MODE_DEC = 2'd0,
      MODE_HEX = 2'd1,
      MODE_BIN = 2'd2,
      MODE_OCT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   // radix overflow guards: any of these bits set means the next shift loses bits
   localparam logic [63:0] HEX_GUARD = 64'hF000_0000_0000_0000;
   localparam logic [63:0] BIN_GUARD = 64'h8000_0000_0000_0000;
   localparam logic [63:0] OCT_GUARD = 64'hE000_0000_0000_0000;
   // largest value that can still take a decimal digit, floor((2^64-1)/10)
   localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;

   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_A       = 8'h61;
   localparam logic [7:0] CHAR_F       = 8'h66;
   localparam logic [7:0] CHAR_B       = 8'h62;
   localparam logic [7:0] CHAR_D       = 8'h64;
   localparam logic [7:0] CHAR_O       = 8'h6F;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // digit value that marks a character that is no digit at all
   localparam logic [4:0] NO_DIGIT = 5'd16;

endpackage : rlti_pkg

`default_nettype wire

// File: design/radix_literal_to_integer.sv
// top level: converts a streamed number literal into an unsigned 64-bit integer
//
// usage:
//   req channel carries one character of a literal per transaction; req_tdata holds
//   the ascii code and req_tlast marks the last character of the literal.
//   letters are folded to lower case. a leading 0x, 0b, 0o or 0d selects radix
//   16, 2, 8 or 10; otherwise the literal is plain decimal.
//   rsp channel carries one transaction per literal, issued for the transaction
//   with req_tlast set: rsp_tdata is the value (zero unless ok) and rsp_tuser the
//   status (ok, invalid digit or form, overflow beyond 64 bits).
// timing:
//   one character per cycle while req_tready is high: the digit append (shift or
//   times ten plus digit) and its overflow compare sit between parser state and
//   result registers. rsp_tvalid rises the cycle after the last character is taken.
// stall behavior:
//   an output register plus a one-entry skid register sit behind the parser;
//   req_tready drops once a second result lands in the skid entry while rsp is
//   stalled, and rises again right after rsp accepts the waiting transaction.
// reset: synchronous active-high reset clears the parser state and drops both
//   output entries; the first character after reset starts a new literal.
`default_nettype none

module radix_literal_to_integer
   import rlti_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // final_char

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [63:0] value
   output      logic [1:0]  rsp_tuser    // [1:0] status
);

   // parser state
   logic [63:0] acc_ff,        acc_in;
   mode_type    mode_ff,       mode_in;
   logic [1:0]  seen_ff,       seen_in;
   logic        first_zero_ff, first_zero_in;
   logic        invalid_ff,    invalid_in;
   logic        overflow_ff,   overflow_in;

   // output register and skid entry
   logic        out_valid_ff,  out_valid_in;
   logic [63:0] out_value_ff,  out_value_in;
   status_type  out_status_ff, out_status_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [63:0] skid_value_ff, skid_value_in;
   status_type  skid_status_ff, skid_status_in;

   // per-character decode
   logic        accept;
   logic [7:0]  char_fold;
   logic [4:0]  digit;
   logic        digit_in_radix;
   logic        is_prefix;
   mode_type    prefix_mode;
   logic [63:0] acc_step;
   logic        step_overflow;
   logic [63:0] acc_upd;
   logic        inv_upd;
   logic        ovf_upd;
   logic        push;
   logic [63:0] res_value;
   status_type  res_status;
   logic        pop;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;
   assign pop        = out_valid_ff && rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_status_ff;

   // fold case, then classify the character
   always_comb begin
      if (req_tdata >= CHAR_UPPER_A && req_tdata <= CHAR_UPPER_Z) begin
         char_fold = req_tdata + CASE_OFFSET;
      end else begin
         char_fold = req_tdata;
      end

      if (char_fold >= CHAR_0 && char_fold <= CHAR_9) begin
         digit = 5'(char_fold - CHAR_0);
      end else if (char_fold >= CHAR_A && char_fold <= CHAR_F) begin
         digit = 5'(char_fold - CHAR_A) + 5'd10;
      end else begin
         digit = NO_DIGIT;
      end

      case (mode_ff)
         MODE_HEX: digit_in_radix = (digit < 5'd16);
         MODE_BIN: digit_in_radix = (digit < 5'd2);
         MODE_OCT: digit_in_radix = (digit < 5'd8);
         default:  digit_in_radix = (digit < 5'd10);
      endcase

      case (char_fold)
         CHAR_X:  prefix_mode = MODE_HEX;
         CHAR_B:  prefix_mode = MODE_BIN;
         CHAR_O:  prefix_mode = MODE_OCT;
         default: prefix_mode = MODE_DEC;
      endcase
      is_prefix = (seen_ff == 2'd1) && first_zero_ff &&
                  (char_fold == CHAR_X || char_fold == CHAR_B ||
                   char_fold == CHAR_O || char_fold == CHAR_D);
   end

   // digit append with exact overflow check for the active radix
   always_comb begin
      case (mode_ff)
         MODE_HEX: begin
            step_overflow = |(acc_ff & HEX_GUARD);
            acc_step      = {acc_ff[59:0], digit[3:0]};
         end
         MODE_BIN: begin
            step_overflow = |(acc_ff & BIN_GUARD);
            acc_step      = {acc_ff[62:0], digit[0]};
         end
         MODE_OCT: begin
            step_overflow = |(acc_ff & OCT_GUARD);
            acc_step      = {acc_ff[60:0], digit[2:0]};
         end
         default: begin
            step_overflow = (acc_ff > DEC_LIMIT) ||
                            ((acc_ff == DEC_LIMIT) && (digit > 5'd5));
            acc_step      = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0} +
                            {59'd0, digit};
         end
      endcase
   end

   // next parser state and result
   always_comb begin
      acc_upd     = acc_ff;
      inv_upd     = invalid_ff;
      ovf_upd     = overflow_ff;
      mode_in     = mode_ff;
      first_zero_in = first_zero_ff;

      if (seen_ff == 2'd0) begin
         if (digit < 5'd10) begin
            acc_upd       = {59'd0, digit};
            first_zero_in = (digit == 5'd0);
         end else begin
            inv_upd = 1'b1;
         end
      end else if (is_prefix) begin
         mode_in = prefix_mode;
         acc_upd = '0;
         if (req_tlast) begin
            inv_upd = 1'b1;   // bare prefix
         end
      end else if (digit_in_radix) begin
         if (!overflow_ff) begin
            if (step_overflow) begin
               ovf_upd = 1'b1;  // accumulator holds after overflow
            end else begin
               acc_upd = acc_step;
            end
         end
      end else begin
         inv_upd = 1'b1;
      end

      if (inv_upd) begin
         res_value  = '0;
         res_status = ST_INVALID;
      end else if (ovf_upd) begin
         res_value  = '0;
         res_status = ST_OVERFLOW;
      end else begin
         res_value  = acc_upd;
         res_status = ST_OK;
      end

      push = accept && req_tlast;

      if (!accept) begin
         acc_in        = acc_ff;
         mode_in       = mode_ff;
         seen_in       = seen_ff;
         first_zero_in = first_zero_ff;
         invalid_in    = invalid_ff;
         overflow_in   = overflow_ff;
      end else if (req_tlast) begin
         // literal done, start clean for the next one
         acc_in        = '0;
         mode_in       = MODE_DEC;
         seen_in       = 2'd0;
         first_zero_in = 1'b0;
         invalid_in    = 1'b0;
         overflow_in   = 1'b0;
      end else begin
         acc_in      = acc_upd;
         seen_in     = (seen_ff == 2'd3) ? seen_ff : seen_ff + 2'd1;
         invalid_in  = inv_upd;
         overflow_in = ovf_upd;
      end
   end

   // output register with skid entry
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_value_in   = out_value_ff;
      out_status_in  = out_status_ff;
      skid_valid_in  = skid_valid_ff;
      skid_value_in  = skid_value_ff;
      skid_status_in = skid_status_ff;

      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in   = 1'b1;
            out_value_in   = skid_value_ff;
            out_status_in  = skid_status_ff;
            skid_valid_in  = push;
            skid_value_in  = res_value;
            skid_status_in = res_status;
         end else begin
            out_valid_in  = push;
            out_value_in  = res_value;
            out_status_in = res_status;
         end
      end else if (push) begin
         skid_valid_in  = 1'b1;
         skid_value_in  = res_value;
         skid_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         mode_ff       <= MODE_DEC;
         seen_ff       <= 2'd0;
         first_zero_ff <= 1'b0;
         invalid_ff    <= 1'b0;
         overflow_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         mode_ff       <= mode_in;
         seen_ff       <= seen_in;
         first_zero_ff <= first_zero_in;
         invalid_ff    <= invalid_in;
         overflow_ff   <= overflow_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff   <= out_value_in;
      out_status_ff  <= out_status_in;
      skid_value_ff  <= skid_value_in;
      skid_status_ff <= skid_status_in;
   end

endmodule : radix_literal_to_integer

`default_nettype wire
